// File: rtl/core/shp3x3_pkg.sv
// Shared types, sizes and helpers for the 3x3 sharpen filter.
// Used by every module of the block but shp3x3_ram; depends on nothing.
package shp3x3_pkg;

	// Frame limits and field sizes
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int PIXEL_BITS  = 8;
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int SUM_W       = 13;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int OROW_W      = $clog2(MAX_HEIGHT);
	localparam int IROW_W      = $clog2(MAX_HEIGHT + 2);
	localparam int WIN_TAPS    = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_W-1:0] MAX_WIDTH_DIM  = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] MAX_HEIGHT_DIM = CFG_W'(MAX_HEIGHT);

	// Item kinds on the pixel channel
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		op_t                   op;
		logic [PIXEL_BITS-1:0] pixel_value;
	} pixel_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] filtered_value;
		logic                    last_of_frame;
	} result_item_t;

	// One column step for the datapath, with its edge masks already decided
	typedef struct packed {
		logic [PIXEL_BITS-1:0] pix;
		logic [COL_W-1:0]      col;
		logic                  use_left;
		logic                  use_right;
		logic                  use_top;
		logic                  use_bot;
		logic                  emit;
		logic                  last;
	} take_cmd_t;

	// Map a register value onto the usable range 1 .. hi
	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		r = v;
		if (r == '0) begin
			r = CFG_W'(1);
		end
		if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/shp3x3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module shp3x3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, and read port returning the old contents on a clash
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/shp3x3_front.sv
// Front end: accepts pixel and flush items, tracks frame positions and
// turns each item it keeps into column steps for the queue. Depends on shp3x3_pkg.
module shp3x3_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pixel_valid,
	output logic                               pixel_ready,
	input  shp3x3_pkg::pixel_item_t            pixel_item,
	input  logic                               cfg_we,
	input  logic [shp3x3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [shp3x3_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                               restart,
	output logic                               push,
	output shp3x3_pkg::take_cmd_t              cmd,
	input  logic                               full
);
	import shp3x3_pkg::*;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [IROW_W-1:0] in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [OROW_W-1:0] out_row_q;
	logic [COL_W-1:0]  out_col_q;

	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;
	logic             filled;
	logic             in_frame;
	logic             is_flush;
	logic             extra;
	logic             wants_take;
	logic             col_wrap;
	logic             orow_end;
	logic             ocol_end;

	// Classify the waiting item against the frame position
	always_comb begin
		w_eff      = clamp_dim(width_q, MAX_WIDTH_DIM);
		h_eff      = clamp_dim(height_q, MAX_HEIGHT_DIM);
		filled     = (in_row_q >= IROW_W'(2)) || ((in_row_q == IROW_W'(1)) && (in_col_q != '0));
		in_frame   = CFG_W'(in_row_q) < h_eff;
		is_flush   = pixel_item.op == OP_FLUSH;
		// a single-row frame needs one silent step before its first flush result
		extra      = pixel_valid && is_flush && !in_frame && !filled;
		wants_take = is_flush ? !in_frame : in_frame;
		col_wrap   = (CFG_W'(in_col_q) + CFG_W'(1)) >= w_eff;
		orow_end   = (CFG_W'(out_row_q) + CFG_W'(1)) >= h_eff;
		ocol_end   = (CFG_W'(out_col_q) + CFG_W'(1)) >= w_eff;

		pixel_ready = !full && !extra;
		push        = pixel_valid && !full && wants_take;

		cmd.pix       = is_flush ? '0 : pixel_item.pixel_value;
		cmd.col       = in_col_q;
		cmd.use_left  = out_col_q != '0;
		cmd.use_right = !ocol_end;
		cmd.use_top   = out_row_q != '0;
		cmd.use_bot   = !orow_end;
		cmd.emit      = !extra && (is_flush || filled);
		cmd.last      = orow_end && ocol_end;

		restart = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));
	end

	// Hold registers and advance frame positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= MAX_WIDTH_DIM;
			height_q  <= MAX_HEIGHT_DIM;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_wdata;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
			if (restart) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end
		end else if (push) begin
			if (cmd.emit && cmd.last) begin
				// frame done: start the next one
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + IROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (cmd.emit) begin
					if (ocol_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

endmodule

// File: rtl/core/shp3x3_queue.sv
// Short command queue between front and back end.
// Depends on shp3x3_pkg for the command type and depth.
module shp3x3_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  shp3x3_pkg::take_cmd_t din,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output shp3x3_pkg::take_cmd_t head
);
	import shp3x3_pkg::*;

	take_cmd_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	// Show occupancy and the oldest entry
	always_comb begin
		full       = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
		head_valid = count_q != '0;
		head       = slot_q[rd_ptr_q];
	end

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("queue popped while empty");
`endif

endmodule

// File: rtl/core/shp3x3_back.sv
// Back end: line stores, 3x3 window, sharpen sum and output register.
// Depends on shp3x3_pkg and shp3x3_ram.
module shp3x3_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     restart,
	input  logic                     head_valid,
	input  shp3x3_pkg::take_cmd_t    head,
	output logic                     pop,
	output logic                     result_valid,
	input  logic                     result_ready,
	output shp3x3_pkg::result_item_t result_item
);
	import shp3x3_pkg::*;

	logic                  cmd_valid_s2;
	take_cmd_t             cmd_s2;
	logic                  fwd_hit_s2;
	logic [PIXEL_BITS-1:0] fwd_top_s2;
	logic [PIXEL_BITS-1:0] fwd_mid_s2;

	logic [PIXEL_BITS-1:0] win_q [WIN_TAPS];
	logic                  result_valid_q;
	result_item_t          result_q;

	logic [PIXEL_BITS-1:0] top_rd;
	logic [PIXEL_BITS-1:0] mid_rd;
	logic [PIXEL_BITS-1:0] top;
	logic [PIXEL_BITS-1:0] mid;
	logic                  adv;
	logic [SUM_W-1:0]      acc;

	// Two rows above the input position, and the row directly above
	shp3x3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_row_two_above (
		.clk     (clk),
		.wr_en   (adv),
		.wr_addr (cmd_s2.col),
		.wr_data (mid),
		.rd_en   (pop),
		.rd_addr (head.col),
		.rd_data (top_rd)
	);

	shp3x3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_row_above (
		.clk     (clk),
		.wr_en   (adv),
		.wr_addr (cmd_s2.col),
		.wr_data (cmd_s2.pix),
		.rd_en   (pop),
		.rd_addr (head.col),
		.rd_data (mid_rd)
	);

	// Handshake between queue, column stage and output register
	always_comb begin
		adv = cmd_valid_s2 && (!cmd_s2.emit || !result_valid_q || result_ready);
		pop = head_valid && (!cmd_valid_s2 || adv);
		// take store data written in the same cycle as the read
		top = fwd_hit_s2 ? fwd_top_s2 : top_rd;
		mid = fwd_hit_s2 ? fwd_mid_s2 : mid_rd;
	end

	// Nine times the centre less the neighbours inside the frame
	always_comb begin
		acc = SUM_W'({win_q[4], 3'b000}) + SUM_W'(win_q[4]);
		if (cmd_s2.use_left) begin
			acc = acc - SUM_W'(win_q[1]);
			if (cmd_s2.use_top) begin
				acc = acc - SUM_W'(win_q[0]);
			end
			if (cmd_s2.use_bot) begin
				acc = acc - SUM_W'(win_q[2]);
			end
		end
		if (cmd_s2.use_top) begin
			acc = acc - SUM_W'(win_q[3]);
		end
		if (cmd_s2.use_bot) begin
			acc = acc - SUM_W'(win_q[5]);
		end
		if (cmd_s2.use_right) begin
			acc = acc - SUM_W'(mid);
			if (cmd_s2.use_top) begin
				acc = acc - SUM_W'(top);
			end
			if (cmd_s2.use_bot) begin
				acc = acc - SUM_W'(cmd_s2.pix);
			end
		end
	end

	// Column stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s2 <= 1'b0;
		end else if (pop) begin
			cmd_valid_s2 <= 1'b1;
		end else if (adv) begin
			cmd_valid_s2 <= 1'b0;
		end
	end

	// Column stage payload, with a bypass of the concurrent store write
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s2     <= head;
			fwd_hit_s2 <= adv && (cmd_s2.col == head.col);
			fwd_top_s2 <= mid;
			fwd_mid_s2 <= cmd_s2.pix;
		end
	end

	// Shift the window one column, drop it at frame end or restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (restart || (adv && cmd_s2.emit && cmd_s2.last)) begin
			for (int i = 0; i < WIN_TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= cmd_s2.pix;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && cmd_s2.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cmd_s2.emit) begin
			result_q.filtered_value <= acc;
			result_q.last_of_frame  <= cmd_s2.last;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

`ifndef SYNTHESIS
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s2.emit) |-> (!result_valid_q || result_ready))
		else $error("result register overwritten before hand-off");
	a_window_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s2.emit && cmd_s2.last) |=>
		(win_q[0] == '0 && win_q[1] == '0 && win_q[2] == '0 &&
		 win_q[3] == '0 && win_q[4] == '0 && win_q[5] == '0))
		else $error("window not cleared after the frame's last result");
`endif

endmodule

// File: rtl/core/sharpen_3x3_convolution_top.sv
// 3x3 sharpen filter, top level: front end, command queue and back end.
// Depends on shp3x3_pkg, shp3x3_front, shp3x3_queue and shp3x3_back.
//
// Usage:
//   Pixels of a frame enter in raster order on the pixel channel
//   (valid/ready, op = pixel). Each result is 9 times the centre less the
//   eight neighbours, neighbours outside the frame counting as zero, as a
//   signed 13-bit value. Results leave on the result channel in raster
//   order, one row and one pixel behind the input; after the final pixel,
//   send one flush item per pending result. last_of_frame marks the frame's
//   final result, after which a new frame begins. Pixels past the frame and
//   flushes before its end are taken and dropped.
//   Rate: one item per cycle while the queue is not full, set by the single
//   column stage that reads and writes both line stores; the first flush of
//   a one-row frame waits for a silent step. Each result passes through the
//   queue, the column stage and the output register.
//   Reset: 1024 x 1024 frame, positions and window cleared; line stores are
//   not cleared. A width or height write restarts the frame.
//   Stall: the output register holds its result; the four-entry queue
//   absorbs items until full, then pixel_ready falls.
module sharpen_3x3_convolution_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pixel_valid,
	output logic                             pixel_ready,
	input  shp3x3_pkg::pixel_item_t          pixel_item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output shp3x3_pkg::result_item_t         result_item,
	input  logic                             cfg_we,
	input  logic [shp3x3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [shp3x3_pkg::CFG_W-1:0]     cfg_wdata
);
	import shp3x3_pkg::*;

	logic      restart;
	logic      push;
	logic      full;
	logic      pop;
	logic      head_valid;
	take_cmd_t cmd;
	take_cmd_t head;

	// Classify items and track frame positions
	shp3x3_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_item  (pixel_item),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.restart     (restart),
		.push        (push),
		.cmd         (cmd),
		.full        (full)
	);

	// Decouple the two ends
	shp3x3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Line stores, window and sum
	shp3x3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (restart),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the 3x3 sharpen filter: directed frames, then random frames.
// Depends on shp3x3_pkg and sharpen_3x3_convolution_top; stands alone otherwise.
module tb;
	import shp3x3_pkg::*;

	// Spare register indexes beyond the defined list
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 1600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	pixel_item_t pixel_item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_item_t result_item;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	pixel_item_t pixel_backlog[$];
	result_item_t expected_results[$];
	int fail_count = 0;
	int useful_items = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	// Mirror of the filter state
	logic [CFG_W-1:0] width_reg = MAX_WIDTH_DIM;
	logic [CFG_W-1:0] height_reg = MAX_HEIGHT_DIM;
	bit [PIXEL_BITS-1:0] above_line[MAX_WIDTH];
	bit [PIXEL_BITS-1:0] two_above_line[MAX_WIDTH];
	bit [PIXEL_BITS-1:0] window_taps[WIN_TAPS];
	int unsigned in_row = 0;
	int unsigned in_col = 0;
	int unsigned out_row = 0;
	int unsigned out_col = 0;

	sharpen_3x3_convolution_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel_item(pixel_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item(result_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Zero and oversize register values fall back to the usable range
	function automatic int unsigned usable_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
		if (v == '0) begin
			return 1;
		end
		if (v > hi) begin
			return hi;
		end
		return 32'(v);
	endfunction

	function automatic void restart_frame();
		for (int i = 0; i < WIN_TAPS; i++) begin
			window_taps[i] = '0;
		end
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
	endfunction

	// Shift one column into the window and return the sum centred on the output position
	function automatic int shift_column(input bit [PIXEL_BITS-1:0] pix);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		bit [PIXEL_BITS-1:0] top;
		bit [PIXEL_BITS-1:0] mid;
		bit lft;
		bit rgt;
		bit up;
		bit dn;
		int sum;
		w = usable_dim(width_reg, MAX_WIDTH);
		h = usable_dim(height_reg, MAX_HEIGHT);
		col = (in_col < MAX_WIDTH) ? in_col : 0;
		top = two_above_line[col];
		mid = above_line[col];
		lft = out_col != 0;
		rgt = out_col + 1 < w;
		up = out_row != 0;
		dn = out_row + 1 < h;
		sum = 9 * int'(window_taps[4]);
		if (lft) begin
			sum -= int'(window_taps[1]);
			if (up) sum -= int'(window_taps[0]);
			if (dn) sum -= int'(window_taps[2]);
		end
		if (up) sum -= int'(window_taps[3]);
		if (dn) sum -= int'(window_taps[5]);
		if (rgt) begin
			sum -= int'(mid);
			if (up) sum -= int'(top);
			if (dn) sum -= int'(pix);
		end
		window_taps[0] = window_taps[3];
		window_taps[1] = window_taps[4];
		window_taps[2] = window_taps[5];
		window_taps[3] = top;
		window_taps[4] = mid;
		window_taps[5] = pix;
		two_above_line[col] = mid;
		above_line[col] = pix;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		return sum;
	endfunction

	// Queue the expected result and advance the output position
	function automatic void release_result(input int sum);
		int unsigned w;
		int unsigned h;
		result_item_t r;
		w = usable_dim(width_reg, MAX_WIDTH);
		h = usable_dim(height_reg, MAX_HEIGHT);
		r.filtered_value = sum[SUM_W-1:0];
		r.last_of_frame = (out_row + 1 >= h) && (out_col + 1 >= w);
		expected_results.push_back(r);
		if (r.last_of_frame) begin
			restart_frame();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endfunction

	function automatic void sharpen_step(input pixel_item_t it);
		int unsigned h;
		bit filled;
		int sum;
		h = usable_dim(height_reg, MAX_HEIGHT);
		filled = in_row >= 2 || (in_row == 1 && in_col >= 1);
		if (it.op == OP_PIXEL) begin
			// drop pixels past the frame
			if (in_row >= h) return;
			sum = shift_column(it.pixel_value);
			if (filled) release_result(sum);
		end else begin
			// drop flushes before the frame's last pixel
			if (in_row < h) return;
			if (!filled) void'(shift_column('0));
			sum = shift_column('0);
			release_result(sum);
		end
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = v;
			restart_frame();
		end else if (idx == REG_IMAGE_HEIGHT) begin
			height_reg = v;
			restart_frame();
		end
	endfunction

	// Present backlog items, holding each until it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pixel_item <= '0;
		end else begin
			if (pixel_valid && pixel_ready) begin
				sharpen_step(pixel_item);
			end
			if (!pixel_valid || pixel_ready) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					pixel_valid <= 1'b1;
					pixel_item <= pixel_backlog.pop_front();
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// Compare each result item against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_item_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result item: filtered_value %0d last_of_frame %0b",
						$signed(result_item.filtered_value), result_item.last_of_frame);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (result_item.filtered_value !== want.filtered_value) begin
						$error("filtered_value: expected %0d, got %0d",
							$signed(want.filtered_value), $signed(result_item.filtered_value));
						fail_count++;
					end
					if (result_item.last_of_frame !== want.last_of_frame) begin
						$error("last_of_frame: expected %0b, got %0b",
							want.last_of_frame, result_item.last_of_frame);
						fail_count++;
					end
				end
			end
			result_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	function automatic void push_item(input op_t op, input logic [PIXEL_BITS-1:0] v);
		pixel_item_t it;
		it.op = op;
		it.pixel_value = v;
		pixel_backlog.push_back(it);
	endfunction

	// Hold off until the block has drained, then let its pipeline empty
	task automatic settle();
		do @(negedge clk);
		while (pixel_backlog.size() != 0 || pixel_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, CFG_W'(v));
		@(negedge clk);
	endtask

	// Queue pixels with the odd early flush mixed in
	function automatic void queue_pixels(input int n);
		logic [PIXEL_BITS-1:0] v;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0) push_item(OP_FLUSH, PIXEL_BITS'($urandom));
			if ($urandom_range(3) == 0) begin
				v = $urandom_range(1) ? '1 : '0;
			end else begin
				v = PIXEL_BITS'($urandom_range(255));
			end
			push_item(OP_PIXEL, v);
		end
		useful_items += n;
	endfunction

	// Maybe stray pixels past the frame, the flushes that release it, then maybe a stray flush
	function automatic void queue_tail(input int w, input int h);
		int flushes;
		flushes = (h >= 2) ? w + 1 : w;
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 2)) push_item(OP_PIXEL, PIXEL_BITS'($urandom));
		end
		repeat (flushes) push_item(OP_FLUSH, PIXEL_BITS'($urandom));
		if ($urandom_range(3) == 0) push_item(OP_FLUSH, '0);
		useful_items += flushes;
	endfunction

	initial begin : stimulus
		int phase;
		int start;
		int wr;
		int hr;
		int w;
		int h;
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_gap_pct = 21;
		recv_stall_pct = 75;

		// One-pixel frame from zero registers: early flush, largest sum, stray pixel and flush
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 0);
		push_item(OP_FLUSH, '0);
		push_item(OP_PIXEL, 8'd255);
		push_item(OP_PIXEL, 8'd0);
		push_item(OP_FLUSH, '0);
		push_item(OP_FLUSH, '1);
		settle();

		// Single-row frame released by flushes alone
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 1);
		push_item(OP_PIXEL, 8'd255);
		push_item(OP_PIXEL, 8'd0);
		push_item(OP_PIXEL, 8'd255);
		repeat (4) push_item(OP_FLUSH, '0);
		settle();

		// Dark centre among bright neighbours gives the smallest sum
		write_reg(REG_IMAGE_HEIGHT, 3);
		for (int i = 0; i < 9; i++) begin
			push_item(OP_PIXEL, (i == 4) ? 8'd0 : 8'd255);
		end
		repeat (4) push_item(OP_FLUSH, '0);
		settle();

		// Random phases, each under its own frame size; four phases for each of the first two idling patterns, then none
		useful_items = 0;
		phase = 0;
		while (useful_items < RANDOM_ITEMS || phase < 10) begin
			if (phase < 4) begin
				send_gap_pct = 21;
				recv_stall_pct = 75;
			end else if (phase < 8) begin
				send_gap_pct = 75;
				recv_stall_pct = 21;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			if (phase == 3) begin
				// widest row: oversize registers, a row and a bit
				write_reg(REG_IMAGE_WIDTH, 2047);
				write_reg(REG_IMAGE_HEIGHT, 2047);
				queue_pixels(MAX_WIDTH + $urandom_range(2, 40));
			end else if (phase == 6) begin
				// tallest frame, cut short after a few rows
				w = $urandom_range(1, 6);
				write_reg(REG_IMAGE_HEIGHT, 2047);
				write_reg(REG_IMAGE_WIDTH, w);
				queue_pixels(w * $urandom_range(3, 6) + $urandom_range(0, w - 1));
			end else if (phase == 9) begin
				// spare-index writes mid-frame must not restart it
				w = $urandom_range(2, 6);
				h = $urandom_range(2, 4);
				write_reg(REG_IMAGE_WIDTH, w);
				write_reg(REG_IMAGE_HEIGHT, h);
				k = $urandom_range(1, w * h - 1);
				queue_pixels(k);
				settle();
				write_reg(REG_SPARE_A, $urandom_range(2047));
				write_reg(REG_SPARE_B, $urandom_range(2047));
				queue_pixels(w * h - k);
				queue_tail(w, h);
			end else begin
				case ($urandom_range(15))
					0: wr = 0;
					1: wr = $urandom_range(9, 40);
					default: wr = $urandom_range(1, 8);
				endcase
				case ($urandom_range(15))
					0: hr = 0;
					1: hr = $urandom_range(7, 12);
					default: hr = $urandom_range(1, 5);
				endcase
				if ($urandom_range(1)) begin
					write_reg(REG_IMAGE_WIDTH, wr);
					write_reg(REG_IMAGE_HEIGHT, hr);
				end else begin
					write_reg(REG_IMAGE_HEIGHT, hr);
					write_reg(REG_IMAGE_WIDTH, wr);
				end
				w = usable_dim(CFG_W'(wr), MAX_WIDTH);
				h = usable_dim(CFG_W'(hr), MAX_HEIGHT);
				start = useful_items;
				while (useful_items - start < 50) begin
					queue_pixels(w * h);
					queue_tail(w, h);
				end
				// leave a broken frame behind now and then
				if (w * h >= 2 && $urandom_range(3) == 0) begin
					queue_pixels($urandom_range(1, w * h - 1));
				end
			end
			settle();
			phase++;
		end

		settle();
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sharpen_3x3_convolution_top.f
rtl/core/shp3x3_pkg.sv
rtl/core/shp3x3_ram.sv
rtl/core/shp3x3_front.sv
rtl/core/shp3x3_queue.sv
rtl/core/shp3x3_back.sv
rtl/core/sharpen_3x3_convolution_top.sv
bench/tb.sv
